// ===== hw/rtl/skl_pkg.sv =====
`default_nettype none

package skl_pkg;

    // Built size of the list
    localparam int DEPTH     = 16;
    localparam int KEY_WIDTH = 32;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int RANK_W    = $clog2(DEPTH);
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Request beat
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [KEY_WIDTH-1:0] key;
        logic [RANK_W-1:0]    rank;
    } skl_req_t;

    // Response beat
    typedef struct packed {
        logic [KEY_WIDTH-1:0] value;
        logic [COUNT_W-1:0]   count;
        logic [STATUS_W-1:0]  status;
    } skl_rsp_t;

    // Per-cell command for one operation
    typedef struct packed {
        logic ins_en;      // insert in progress
        logic shift_left;  // remove at or below this slot: take right neighbor
    } skl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skl_cell.sv =====
`default_nettype none

module skl_cell
    import skl_pkg::*;
(
    input  wire logic                 clk,
    input  wire skl_cmd_t             cmd,
    input  wire logic                 occupied,
    input  wire logic [KEY_WIDTH-1:0] new_key,
    input  wire logic                 left_less,
    input  wire logic [KEY_WIDTH-1:0] left_key,
    input  wire logic [KEY_WIDTH-1:0] right_key,
    output logic                      less,
    output logic [KEY_WIDTH-1:0]      key
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    // Stored key strictly below the incoming one
    assign less = occupied && (key_reg < new_key);
    assign key  = key_reg;

    // Insert: keep, take the new key at the boundary, or shift right.
    // Remove: shift left from the removed slot upward.
    always_comb
    begin
        key_next = key_reg;
        if (cmd.ins_en && !less)
        begin
            key_next = left_less ? new_key : left_key;
        end
        else if (cmd.shift_left)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_list_unit.sv =====
// The response is registered and appears the cycle after its request is taken.
// Throughput: 1 request per cycle unless rsp_ready stalls; every cell compares
// and shifts in parallel; the output register refills in the cycle it drains.
// Reset: the key count and capacity (16) reset at once; the key cells have
// no reset and are read only below the count.
`default_nettype none

module sorted_key_list_unit
    import skl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire skl_req_t     req,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output skl_rsp_t          rsp,
    input  wire logic         cfg_we,
    input  wire logic [4:0]   cfg_wdata
);

    logic [4:0]         capacity_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               rsp_valid_reg;
    skl_rsp_t           rsp_reg;
    skl_rsp_t           rsp_next;

    logic                 accept;
    logic                 is_ins;
    logic                 is_lookup;
    logic                 is_rem;
    logic                 full;
    logic                 rank_ok;
    logic [COUNT_W-1:0]   rank_ext;
    logic [KEY_WIDTH-1:0] lookup_key;

    logic                 cell_less [DEPTH];
    logic [KEY_WIDTH-1:0] cell_key  [DEPTH];
    skl_cmd_t             cell_cmd  [DEPTH];

    // Handshake: output register parts the two sides
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Decode and range checks
    assign is_ins    = (req.mode == MODE_INSERT);
    assign is_lookup = (req.mode == MODE_LOOKUP);
    assign is_rem    = (req.mode == MODE_REMOVE);
    assign rank_ext  = COUNT_W'(req.rank);
    assign rank_ok   = rank_ext < count_reg;

    // Full when count reaches capacity clipped to the built depth
    always_comb
    begin
        if (capacity_reg > 5'(DEPTH))
        begin
            full = (count_reg >= COUNT_W'(DEPTH));
        end
        else
        begin
            full = (count_reg >= COUNT_W'(capacity_reg)) ||
                   (count_reg >= COUNT_W'(DEPTH));
        end
    end

    // Row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                 left_less_w;
        logic [KEY_WIDTH-1:0] left_key_w;
        logic [KEY_WIDTH-1:0] right_key_w;

        if (i == 0)
        begin : g_first
            assign left_less_w = 1'b1;
            assign left_key_w  = req.key;
        end
        else
        begin : g_mid
            assign left_less_w = cell_less[i-1];
            assign left_key_w  = cell_key[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_key_w = cell_key[i];
        end
        else
        begin : g_inner
            assign right_key_w = cell_key[i+1];
        end

        assign cell_cmd[i].ins_en     = accept && is_ins && !full;
        assign cell_cmd[i].shift_left = accept && is_rem && rank_ok &&
                                        (RANK_W'(i) >= req.rank);

        skl_cell u_cell (
            .clk       (clk),
            .cmd       (cell_cmd[i]),
            .occupied  (COUNT_W'(i) < count_reg),
            .new_key   (req.key),
            .left_less (left_less_w),
            .left_key  (left_key_w),
            .right_key (right_key_w),
            .less      (cell_less[i]),
            .key       (cell_key[i])
        );
    end

    // Lookup read: one-hot select over the cells
    always_comb
    begin
        lookup_key = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (req.rank == RANK_W'(i))
            begin
                lookup_key = lookup_key | cell_key[i];
            end
        end
    end

    // Response and count update
    always_comb
    begin
        count_next      = count_reg;
        rsp_next.value  = '0;
        rsp_next.status = ST_OK;
        priority if (is_ins)
        begin
            if (full)
            begin
                rsp_next.status = ST_FULL;
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
        else if (is_lookup)
        begin
            if (rank_ok)
            begin
                rsp_next.value = lookup_key;
            end
            else
            begin
                rsp_next.status = ST_RANGE;
            end
        end
        else if (is_rem)
        begin
            if (rank_ok)
            begin
                count_next = count_reg - COUNT_W'(1);
            end
            else
            begin
                rsp_next.status = ST_RANGE;
            end
        end
        else
        begin
            count_next = count_reg;
        end
        rsp_next.count = count_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= 5'(DEPTH);
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("key count above depth");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg && (rsp_reg.count == count_reg))
        else $error("response missing or count mismatch");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a request");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_ins && full |=> $stable(count_reg) &&
        (rsp_reg.status == ST_FULL))
        else $error("refused insert changed count");
`endif

endmodule

`default_nettype wire
